@@ rtl/hba_pkg.sv @@
// Shared types and constants of the HSP brightness adjust unit.
// No dependencies; every other file in rtl/ imports this package.
package hba_pkg;

    localparam int          INTERNAL_FRAC_BITS = 16;
    localparam int          CFG_ADDR_W         = 1;
    localparam int          CFG_DATA_W         = 16;
    localparam logic [15:0] GAIN_UNITY         = 16'd256;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_IDX_GAIN  = 1'b0,
        CFG_IDX_ALPHA = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } t_chan;

    // Pipeline control handed to each arithmetic unit.
    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

endpackage

@@ rtl/hba_isqrt.sv @@
// Pipelined integer square root, one root bit per stage, with a sideband.
// Depends on hba_pkg (t_pipe_ctl).
module hba_isqrt import hba_pkg::*; #(
    parameter int ROOT_W = 16,
    parameter int SIDE_W = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_pipe_ctl             i_ctl,
    input  logic [2*ROOT_W-1:0]   i_rad,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [ROOT_W-1:0]     o_root,
    output logic [SIDE_W-1:0]     o_side
);
    localparam int RAD_W = 2 * ROOT_W;

    logic              r_vld  [ROOT_W];
    logic [RAD_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SIDE_W-1:0] r_side [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int BIT = ROOT_W - 1 - k;
        logic              vld_in;
        logic [RAD_W-1:0]  rem_in;
        logic [RAD_W-1:0]  trial;
        logic [ROOT_W-1:0] root_in;
        logic [SIDE_W-1:0] side_in;

        if (k == 0) begin : g_first
            assign vld_in  = i_ctl.valid;
            assign rem_in  = i_rad;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign side_in = r_side[k-1];
        end

        // (root + 2^b)^2 - root^2; low root bits are still zero
        assign trial = (RAD_W'(root_in) << (BIT + 1)) | (RAD_W'(1) << (2 * BIT));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                if (rem_in >= trial) begin
                    r_rem[k]  <= rem_in - trial;
                    r_root[k] <= root_in | (ROOT_W'(1) << BIT);
                end else begin
                    r_rem[k]  <= rem_in;
                    r_root[k] <= root_in;
                end
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

@@ rtl/hba_frac_div.sv @@
// Pipelined fraction divider: floor(num * 2^FRAC_W / den) for num <= den,
// one quotient bit per stage over several lanes. Depends on hba_pkg.
module hba_frac_div import hba_pkg::*; #(
    parameter int NUM_W  = 11,
    parameter int FRAC_W = 16,
    parameter int LANES  = 2,
    parameter int SIDE_W = 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_pipe_ctl                        i_ctl,
    input  logic [LANES-1:0][NUM_W-1:0]      i_num,
    input  logic [LANES-1:0][NUM_W-1:0]      i_den,
    input  logic [SIDE_W-1:0]                i_side,
    output logic                             o_valid,
    output logic [LANES-1:0][FRAC_W:0]       o_quot,
    output logic [SIDE_W-1:0]                o_side
);
    localparam int STAGES = FRAC_W + 1;

    logic                          r_vld  [STAGES];
    logic [LANES-1:0][NUM_W-1:0]   r_rem  [STAGES];
    logic [LANES-1:0][NUM_W-1:0]   r_den  [STAGES];
    logic [LANES-1:0][FRAC_W:0]    r_quot [STAGES];
    logic [SIDE_W-1:0]             r_side [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam int BIT = FRAC_W - k;
        logic                        vld_in;
        logic [LANES-1:0][NUM_W:0]   part;
        logic [LANES-1:0][NUM_W-1:0] den_in;
        logic [LANES-1:0][FRAC_W:0]  quot_in;
        logic [SIDE_W-1:0]           side_in;
        logic [LANES-1:0][NUM_W-1:0] rem_nx;
        logic [LANES-1:0][FRAC_W:0]  quot_nx;

        if (k == 0) begin : g_first
            assign vld_in  = i_ctl.valid;
            assign den_in  = i_den;
            assign quot_in = '0;
            assign side_in = i_side;
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign part[l] = {1'b0, i_num[l]};
            end
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign den_in  = r_den[k-1];
            assign quot_in = r_quot[k-1];
            assign side_in = r_side[k-1];
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign part[l] = {r_rem[k-1][l], 1'b0};
            end
        end

        always_comb begin
            logic [NUM_W:0] diff;
            for (int l = 0; l < LANES; l++) begin
                diff = part[l] - {1'b0, den_in[l]};
                if (part[l] >= {1'b0, den_in[l]}) begin
                    rem_nx[l]  = diff[NUM_W-1:0];
                    quot_nx[l] = quot_in[l] | ((FRAC_W + 1)'(1) << BIT);
                end else begin
                    rem_nx[l]  = part[l][NUM_W-1:0];
                    quot_nx[l] = quot_in[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[k]  <= rem_nx;
                r_den[k]  <= den_in;
                r_quot[k] <= quot_nx;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_quot  = r_quot[STAGES-1];
    assign o_side  = r_side[STAGES-1];

endmodule

@@ rtl/hsp_brightness_adjust_unit.sv @@
// Top level of the HSP brightness adjust unit: stream ports, config registers
// and the pixel pipeline. Depends on hba_pkg, hba_isqrt and hba_frac_div.
//
// Takes one RGB(A) pixel per clock and returns one adjusted pixel per clock,
// in order. Each pixel goes to hue / min-max ratio / perceived brightness P,
// P is scaled by brightness_gain (Q8.8), and the pixel is rebuilt in RGB with
// each channel floored and saturated at 255. A gain of 256 returns the pixel
// unchanged; alpha passes when has_alpha is set and reads zero otherwise; tlast
// follows its pixel. The pipeline holds two square-root pipelines (16 and
// FRAC_BITS+1 stages), the ratio divider (FRAC_BITS+1 stages) and the
// eight-stage channel divider. The whole pipeline advances together: it holds
// while the output register carries a request that the sink has not taken.
// Write config only when the pipeline is empty.
module hsp_brightness_adjust_unit import hba_pkg::*; #(
    parameter int FRAC_BITS = INTERNAL_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // pixel input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,  // red_in, green_in, blue_in, alpha_in
    input  logic                  s_axis_tlast,  // last_pixel
    // pixel output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,  // red_out, green_out, blue_out, alpha_out
    output logic                  m_axis_tlast   // last_out
);
    localparam int F  = FRAC_BITS;
    localparam longint unsigned ONE_L = 64'd1 << F;
    localparam logic [F:0]   ONE     = (F + 1)'(ONE_L);
    localparam logic [F-1:0] W_RED   = F'((64'd299 * ONE_L + 64'd500) / 64'd1000);
    localparam logic [F-1:0] W_GREEN = F'((64'd587 * ONE_L + 64'd500) / 64'd1000);
    localparam logic [F-1:0] W_BLUE  = F'((64'd114 * ONE_L + 64'd500) / 64'd1000);

    localparam int BASE_W = 33;              // {rgb, alpha, last}
    localparam int SA_W   = BASE_W + 38;     // + hue num/den, min/max
    localparam int SB_W   = BASE_W + 24;     // + scaled brightness
    localparam int SD_W   = SB_W + 2 * F + 5;
    localparam int XW     = F + 16;          // pk * ratio / 256
    localparam int RW     = F + 9;           // channel divider remainder

    // ---------------------------------------------------------------- helpers
    function automatic logic [10:0] times6(input logic [7:0] x);
        return ({3'b0, x} << 2) + ({3'b0, x} << 1);
    endfunction

    // sector -> (largest, middle, smallest) channel
    function automatic t_chan big_of(input logic [2:0] s);
        case (s)
            3'd1, 3'd2: return CH_GREEN;
            3'd3, 3'd4: return CH_BLUE;
            default:    return CH_RED;
        endcase
    endfunction

    function automatic t_chan mid_of(input logic [2:0] s);
        case (s)
            3'd1, 3'd4: return CH_RED;
            3'd2, 3'd5: return CH_BLUE;
            default:    return CH_GREEN;
        endcase
    endfunction

    function automatic t_chan small_of(input logic [2:0] s);
        case (s)
            3'd2, 3'd3: return CH_RED;
            3'd4, 3'd5: return CH_GREEN;
            default:    return CH_BLUE;
        endcase
    endfunction

    function automatic logic [F-1:0] weight(input t_chan c);
        case (c)
            CH_GREEN: return W_GREEN;
            CH_BLUE:  return W_BLUE;
            default:  return W_RED;
        endcase
    endfunction

    // ------------------------------------------------------- config registers
    logic [15:0] r_gain;
    logic        r_has_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= GAIN_UNITY;
            r_has_alpha <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_IDX_GAIN:  r_gain      <= i_cfg_wdata;
                CFG_IDX_ALPHA: r_has_alpha <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------ pipeline enable
    logic      r_out_valid;
    logic      en;
    t_pipe_ctl ctl_p, ctl_div, ctl_d;

    // Advance everything unless the output request is stuck.
    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    // --------------------------------------------- stage 1: classify, square
    logic [7:0]  c_r, c_g, c_b;
    logic [7:0]  c_mx, c_mn, c_d;
    logic [10:0] c_n, c_hden;

    assign c_r = s_axis_tdata[7:0];
    assign c_g = s_axis_tdata[15:8];
    assign c_b = s_axis_tdata[23:16];

    always_comb begin
        if (c_r >= c_g && c_r >= c_b) begin
            c_mx = c_r;
            if (c_b >= c_g) begin
                c_mn = c_g; c_d = c_r - c_g;
                c_n  = times6(c_d) - 11'(c_b - c_g);
            end else begin
                c_mn = c_b; c_d = c_r - c_b;
                c_n  = 11'(c_g - c_b);
            end
        end else if (c_g >= c_r && c_g >= c_b) begin
            c_mx = c_g;
            if (c_r >= c_b) begin
                c_mn = c_b; c_d = c_g - c_b;
                c_n  = (11'(c_d) << 1) - 11'(c_r - c_b);
            end else begin
                c_mn = c_r; c_d = c_g - c_r;
                c_n  = (11'(c_d) << 1) + 11'(c_b - c_r);
            end
        end else begin
            c_mx = c_b;
            if (c_g >= c_r) begin
                c_mn = c_r; c_d = c_b - c_r;
                c_n  = (11'(c_d) << 2) - 11'(c_g - c_r);
            end else begin
                c_mn = c_g; c_d = c_b - c_g;
                c_n  = (11'(c_d) << 2) + 11'(c_r - c_g);
            end
        end
        // grey: hue zero over a harmless divisor
        c_hden = times6(c_d);
        if (c_mx == c_mn) begin
            c_n    = '0;
            c_hden = 11'd6;
        end
    end

    logic             r1_valid;
    logic [SA_W-1:0]  r1_side;
    logic [15:0]      r1_sq_r, r1_sq_g, r1_sq_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_valid <= 1'b0;
        else if (en)  r1_valid <= s_axis_tvalid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // black: min/max ratio of one
            r1_side <= {s_axis_tdata, s_axis_tlast, c_n, c_hden,
                        (c_mx == 8'd0) ? 8'd1 : c_mn,
                        (c_mx == 8'd0) ? 8'd1 : c_mx};
            r1_sq_r <= 16'(c_r) * 16'(c_r);
            r1_sq_g <= 16'(c_g) * 16'(c_g);
            r1_sq_b <= 16'(c_b) * 16'(c_b);
        end
    end

    // ------------------------------------------------ stage 2: weight squares
    logic             r2_valid;
    logic [SA_W-1:0]  r2_side;
    logic [F+15:0]    r2_pr, r2_pg, r2_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_valid <= 1'b0;
        else if (en)  r2_valid <= r1_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_side <= r1_side;
            r2_pr   <= (F + 16)'(r1_sq_r) * (F + 16)'(W_RED);
            r2_pg   <= (F + 16)'(r1_sq_g) * (F + 16)'(W_GREEN);
            r2_pb   <= (F + 16)'(r1_sq_b) * (F + 16)'(W_BLUE);
        end
    end

    // ----------------------------------------- stage 3: sum, scale to Q16.16
    logic [F+17:0]   c3_sum;
    logic [F+33:0]   c3_wide;
    logic            r3_valid;
    logic [SA_W-1:0] r3_side;
    logic [31:0]     r3_v;

    assign c3_sum  = (F + 18)'(r2_pr) + (F + 18)'(r2_pg) + (F + 18)'(r2_pb);
    assign c3_wide = {c3_sum, 16'b0} >> F;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_valid <= 1'b0;
        else if (en)  r3_valid <= r2_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_side <= r2_side;
            r3_v    <= c3_wide[31:0];
        end
    end

    // ------------------------------------------ perceived brightness, Q8.8
    logic            p_valid;
    logic [15:0]     p_root;
    logic [SA_W-1:0] p_side;
    logic [SA_W-1:0] p_side_in;

    assign ctl_p     = '{en: en, valid: r3_valid};
    assign p_side_in = r3_side;

    hba_isqrt #(
        .ROOT_W (16),
        .SIDE_W (SA_W)
    ) u_isqrt_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_p),
        .i_rad   (r3_v),
        .i_side  (p_side_in),
        .o_valid (p_valid),
        .o_root  (p_root),
        .o_side  (p_side)
    );

    // --------------------------------------------------- stage 4: apply gain
    logic [31:0]       c4_prod;
    logic              r4_valid;
    logic [BASE_W-1:0] r4_base;
    logic [23:0]       r4_pk;
    logic [10:0]       r4_hnum, r4_hden;
    logic [7:0]        r4_mnum, r4_mden;

    assign c4_prod = 32'(p_root) * 32'(r_gain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_valid <= 1'b0;
        else if (en)  r4_valid <= p_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_base <= p_side[SA_W-1:38];
            r4_hnum <= p_side[37:27];
            r4_hden <= p_side[26:16];
            r4_mnum <= p_side[15:8];
            r4_mden <= p_side[7:0];
            r4_pk   <= c4_prod[31:8];
        end
    end

    // ------------------------------------------- hue and min/max ratio
    logic                 dv_valid;
    logic [1:0][F:0]      dv_quot;
    logic [SB_W-1:0]      dv_side;

    assign ctl_div = '{en: en, valid: r4_valid};

    hba_frac_div #(
        .NUM_W  (11),
        .FRAC_W (F),
        .LANES  (2),
        .SIDE_W (SB_W)
    ) u_ratio_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_div),
        .i_num   ({{3'b0, r4_mnum}, r4_hnum}),
        .i_den   ({{3'b0, r4_mden}, r4_hden}),
        .i_side  ({r4_base, r4_pk}),
        .o_valid (dv_valid),
        .o_quot  (dv_quot),
        .o_side  (dv_side)
    );

    // --------------------------------------- stage 5: sector and local hue
    logic [F+2:0]    c5_h6, c5_lo, c5_hi, c5_h;
    logic [2:0]      c5_top, c5_s;
    logic            r5_valid;
    logic [2:0]      r5_s;
    logic [F:0]      r5_h, r5_m;
    logic [SB_W-1:0] r5_side;

    assign c5_h6  = ({2'b0, dv_quot[0]} << 2) + ({2'b0, dv_quot[0]} << 1);
    assign c5_top = c5_h6[F+2:F];
    assign c5_s   = (c5_top > 3'd5) ? 3'd5 : c5_top;
    assign c5_lo  = {c5_s, F'(0)};
    assign c5_hi  = {c5_s + 3'd1, F'(0)};
    // odd sectors run the local hue backward
    assign c5_h   = c5_s[0] ? (c5_hi - c5_h6) : (c5_h6 - c5_lo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_valid <= 1'b0;
        else if (en)  r5_valid <= dv_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_s    <= c5_s;
            r5_h    <= c5_h[F:0];
            r5_m    <= dv_quot[1];
            r5_side <= dv_side;
        end
    end

    // ------------------------------------- stage 6: h * (ONE - M)
    logic            r6_valid;
    logic [2:0]      r6_s;
    logic [F:0]      r6_m;
    logic [2*F+1:0]  r6_prod;
    logic [SB_W-1:0] r6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_valid <= 1'b0;
        else if (en)  r6_valid <= r5_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_s    <= r5_s;
            r6_m    <= r5_m;
            r6_prod <= (2 * F + 2)'(r5_h) * (2 * F + 2)'(ONE - r5_m);
            r6_side <= r5_side;
        end
    end

    // ------------------------------------------------- stage 7: middle ratio
    logic            r7_valid;
    logic [2:0]      r7_s;
    logic [F:0]      r7_m, r7_q;
    logic [SB_W-1:0] r7_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_valid <= 1'b0;
        else if (en)  r7_valid <= r6_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_s    <= r6_s;
            r7_m    <= r6_m;
            r7_q    <= r6_m + r6_prod[2*F:F];
            r7_side <= r6_side;
        end
    end

    // --------------------------------------------- stage 8: square the ratios
    logic [2*F+1:0]  c8_qq, c8_mm;
    logic            r8_valid;
    logic [2:0]      r8_s;
    logic [F:0]      r8_m, r8_q, r8_qq, r8_mm;
    logic [SB_W-1:0] r8_side;

    assign c8_qq = (2 * F + 2)'(r7_q) * (2 * F + 2)'(r7_q);
    assign c8_mm = (2 * F + 2)'(r7_m) * (2 * F + 2)'(r7_m);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8_valid <= 1'b0;
        else if (en)  r8_valid <= r7_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_s    <= r7_s;
            r8_m    <= r7_m;
            r8_q    <= r7_q;
            r8_qq   <= c8_qq[2*F:F];
            r8_mm   <= c8_mm[2*F:F];
            r8_side <= r7_side;
        end
    end

    // ------------------------------------------ stage 9: weight the squares
    logic [2*F:0]    c9_tm, c9_ts;
    logic            r9_valid;
    logic [2:0]      r9_s;
    logic [F:0]      r9_m, r9_q, r9_tm, r9_ts;
    logic [F-1:0]    r9_wbig;
    logic [SB_W-1:0] r9_side;

    assign c9_tm = (2 * F + 1)'(weight(mid_of(r8_s)))   * (2 * F + 1)'(r8_qq);
    assign c9_ts = (2 * F + 1)'(weight(small_of(r8_s))) * (2 * F + 1)'(r8_mm);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r9_valid <= 1'b0;
        else if (en)  r9_valid <= r8_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_s    <= r8_s;
            r9_m    <= r8_m;
            r9_q    <= r8_q;
            r9_wbig <= weight(big_of(r8_s));
            r9_tm   <= c9_tm[2*F:F];
            r9_ts   <= c9_ts[2*F:F];
            r9_side <= r8_side;
        end
    end

    // ---------------------------------------- stage 10: brightness divisor D
    logic [F+1:0]    c10_d;
    logic            r10_valid;
    logic [2*F+1:0]  r10_rad;
    logic [SD_W-1:0] r10_side;

    assign c10_d = (F + 2)'(r9_wbig) + (F + 2)'(r9_tm) + (F + 2)'(r9_ts);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r10_valid <= 1'b0;
        else if (en)  r10_valid <= r9_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_rad  <= {c10_d, F'(0)};
            r10_side <= {r9_side, r9_q, r9_m, r9_s};
        end
    end

    // --------------------------------------------------------- sqrt(D * ONE)
    logic            d_valid;
    logic [F:0]      d_root;
    logic [SD_W-1:0] d_side;
    logic [2:0]      d_s;
    logic [F:0]      d_m, d_q;
    logic [23:0]     d_pk;

    assign ctl_d = '{en: en, valid: r10_valid};

    hba_isqrt #(
        .ROOT_W (F + 1),
        .SIDE_W (SD_W)
    ) u_isqrt_d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_d),
        .i_rad   (r10_rad),
        .i_side  (r10_side),
        .o_valid (d_valid),
        .o_root  (d_root),
        .o_side  (d_side)
    );

    assign d_s  = d_side[2:0];
    assign d_m  = d_side[F+3:3];
    assign d_q  = d_side[2*F+4:F+4];
    assign d_pk = d_side[2*F+28:2*F+5];

    // ------------------------------------ stage 11: channel numerators
    logic [F+24:0]     c11_xq, c11_xm;
    logic              r11_valid;
    logic [2:0]        r11_s;
    logic [F:0]        r11_rd;
    logic [XW-1:0]     r11_x [3];
    logic [BASE_W-1:0] r11_base;

    assign c11_xq = (F + 25)'(d_pk) * (F + 25)'(d_q);
    assign c11_xm = (F + 25)'(d_pk) * (F + 25)'(d_m);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r11_valid <= 1'b0;
        else if (en)  r11_valid <= d_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_s    <= d_s;
            r11_rd   <= (d_root == '0) ? (F + 1)'(1) : d_root;
            r11_x[0] <= XW'({d_pk, F'(0)} >> 8);
            r11_x[1] <= c11_xq[XW+7:8];
            r11_x[2] <= c11_xm[XW+7:8];
            r11_base <= d_side[SD_W-1:SB_W - BASE_W + 2 * F + 5 + 24 - 24];
        end
    end

    // ---------------------- channel divider: saturate, then 8 quotient bits
    logic              r_cd_valid [8];
    logic [2:0][RW-1:0] r_cd_rem  [8];
    logic [2:0][7:0]   r_cd_q     [8];
    logic [2:0]        r_cd_sat   [8];
    logic [F:0]        r_cd_rd    [8];
    logic [2:0]        r_cd_s     [8];
    logic [BASE_W-1:0] r_cd_base  [8];

    for (genvar j = 0; j < 8; j++) begin : g_cdiv
        localparam int BIT = 7 - j;
        logic               vld_in;
        logic [2:0][RW-1:0] rem_in;
        logic [2:0][7:0]    q_in;
        logic [2:0]         sat_in;
        logic [F:0]         rd_in;
        logic [2:0]         s_in;
        logic [BASE_W-1:0]  base_in;
        logic [RW-1:0]      trial;
        logic [2:0][RW-1:0] rem_nx;
        logic [2:0][7:0]    q_nx;

        if (j == 0) begin : g_first
            assign vld_in  = r11_valid;
            assign rd_in   = r11_rd;
            assign s_in    = r11_s;
            assign base_in = r11_base;
            assign q_in    = '0;
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign rem_in[l] = r11_x[l][RW-1:0];
                assign sat_in[l] = r11_x[l] >= XW'({r11_rd, 8'b0});
            end
        end else begin : g_next
            assign vld_in  = r_cd_valid[j-1];
            assign rd_in   = r_cd_rd[j-1];
            assign s_in    = r_cd_s[j-1];
            assign base_in = r_cd_base[j-1];
            assign q_in    = r_cd_q[j-1];
            assign rem_in  = r_cd_rem[j-1];
            assign sat_in  = r_cd_sat[j-1];
        end

        assign trial = RW'(rd_in) << BIT;

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                if (rem_in[l] >= trial) begin
                    rem_nx[l] = rem_in[l] - trial;
                    q_nx[l]   = q_in[l] | (8'd1 << BIT);
                end else begin
                    rem_nx[l] = rem_in[l];
                    q_nx[l]   = q_in[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n)   r_cd_valid[j] <= 1'b0;
            else if (en)    r_cd_valid[j] <= vld_in;
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cd_rem[j]  <= rem_nx;
                r_cd_q[j]    <= q_nx;
                r_cd_sat[j]  <= sat_in;
                r_cd_rd[j]   <= rd_in;
                r_cd_s[j]    <= s_in;
                r_cd_base[j] <= base_in;
            end
        end
    end

    // ------------------------------------- output: map sector, bypass, alpha
    logic [7:0]  c_v [3];
    logic [7:0]  c_out [3];
    t_chan       c_big, c_mid;
    logic [31:0] r_out_data;
    logic        r_out_last;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            c_v[l] = r_cd_sat[7][l] ? 8'hFF : r_cd_q[7][l];
        end
        c_big = big_of(r_cd_s[7]);
        c_mid = mid_of(r_cd_s[7]);
        for (int c = 0; c < 3; c++) begin
            if (c_big == t_chan'(c))      c_out[c] = c_v[0];
            else if (c_mid == t_chan'(c)) c_out[c] = c_v[1];
            else                          c_out[c] = c_v[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_out_valid <= 1'b0;
        else if (en)   r_out_valid <= r_cd_valid[7];
    end

    // base holds {tdata, tlast}: alpha in [32:25], rgb in [24:1], tlast in [0]
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data[31:24] <= r_has_alpha ? r_cd_base[7][32:25] : 8'd0;
            // unity gain: hand the pixel back untouched
            if (r_gain == GAIN_UNITY) begin
                r_out_data[23:0] <= r_cd_base[7][24:1];
            end else begin
                r_out_data[23:0] <= {c_out[CH_BLUE], c_out[CH_GREEN], c_out[CH_RED]};
            end
            r_out_last <= r_cd_base[7][0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_root_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_valid |-> d_root != '0)
        else $error("brightness divisor root is zero");

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r5_valid |-> r5_s <= 3'd5)
        else $error("hue sector out of range");

    a_alpha_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_cd_valid[7] && !r_has_alpha) |=> m_axis_tdata[31:24] == 8'd0)
        else $error("alpha leaked without has_alpha");

    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_cd_valid[7] && r_gain == GAIN_UNITY)
        |=> m_axis_tdata[23:0] == $past(r_cd_base[7][24:1]))
        else $error("unity gain changed the pixel");
`endif

endmodule
